FILE: hdl/edge_detect_3x3_stream_macros.svh
// Assertion macros used by the edge detector datapath.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef EDGE_DETECT_3X3_STREAM_MACROS_SVH
`define EDGE_DETECT_3X3_STREAM_MACROS_SVH
`ifndef ASSERT_OFF
`define ED3_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ED3_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ED3_ASSERT(label, clk, rstn, prop, msg)
`define ED3_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

FILE: hdl/ed3_pkg.sv
// Shared constants and control/status types of the 3x3 edge detector.
// No dependencies; imported by the controller, datapath and top level.
package ed3_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 63;
    localparam int PIX_W         = 8;
    localparam int COEF_W        = 7;
    localparam int TAPS          = 9;
    localparam int ACC_W         = 19;
    localparam int SQ_W          = 36;
    localparam int GAIN_W        = 16;
    localparam int ROW_W         = 13;
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd7;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [3:0] MAC_LAST = 4'd8;
    localparam logic [7:0] PIX_MAX  = 8'd255;

    typedef struct packed {
        logic accept;
        logic win;
        logic mac_clear;
        logic mac_step;
        logic sq;
        logic sum;
        logic mul;
        logic push;
    } ed3_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic emit;
        logic zero;
        logic mac_done;
        logic out_free;
    } ed3_status_t;

endpackage

FILE: hdl/edge_detect_3x3_stream.sv
// 3x3 edge detector on an 8-bit grayscale pixel stream: one or two signed
// Q2.4 kernels, magnitude or squared gradient, thresholded or scaled. Each
// input transaction is handled to completion before the next is taken: a
// pixel with an interior result takes the line memory read, window update,
// shared tap-by-tap multiply-accumulate, square, sum, gain product and
// output register load; a border pixel skips from window update to output
// load, a silent pixel ends after the window update, and a flush goes from
// the read to the output load only when it emits. A held result does not
// block acceptance of the next transaction; only the next load of the output
// register waits for it. Results lag pixels by width+1 places; flush
// transactions (tuser 1) drain a frame's tail and mark its end in tlast.
// Depends on ed3_pkg, ed3_ctrl and ed3_datapath.
module edge_detect_3x3_stream #(
    parameter int MAX_WIDTH = ed3_pkg::DEF_MAX_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ed3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ed3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // pixel[7:0]
    input  logic                           s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // edge_value[7:0]
    output logic                           m_tlast
);
    import ed3_pkg::*;

    ed3_cmd_t    cmd;
    ed3_status_t status;

    ed3_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ed3_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: hdl/ed3_ctrl.sv
// Controller state machine of the edge detector: sequences one transaction.
// Depends on ed3_pkg for the command and status structs.
module ed3_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ed3_pkg::ed3_status_t status,
    output ed3_pkg::ed3_cmd_t    cmd
);
    import ed3_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WIN, S_MAC, S_SQ, S_SUM, S_MUL, S_OUT
    } state_t;

    state_t state_reg, state_next;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_READ;
            S_READ: begin
                if (!status.is_flush) state_next = S_WIN;
                else if (status.emit) state_next = S_OUT;
                else                  state_next = S_IDLE;
            end
            S_WIN: begin
                if (!status.emit)     state_next = S_IDLE;
                else if (status.zero) state_next = S_OUT;
                else                  state_next = S_MAC;
            end
            S_MAC: if (status.mac_done) state_next = S_SQ;
            S_SQ:  state_next = S_SUM;
            S_SUM: state_next = S_MUL;
            S_MUL: state_next = S_OUT;
            S_OUT: if (status.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    assign s_tready      = (state_reg == S_IDLE);
    assign cmd.accept    = s_tready && s_tvalid;
    assign cmd.win       = (state_reg == S_WIN);
    assign cmd.mac_clear = (state_reg == S_WIN);
    assign cmd.mac_step  = (state_reg == S_MAC);
    assign cmd.sq        = (state_reg == S_SQ);
    assign cmd.sum       = (state_reg == S_SUM);
    assign cmd.mul       = (state_reg == S_MUL);
    assign cmd.push      = (state_reg == S_OUT) && status.out_free;

endmodule

FILE: hdl/ed3_datapath.sv
// Datapath of the edge detector: configuration, counters, line memories,
// window, multiply-accumulate, output stage. Depends on ed3_pkg and macros.
`include "edge_detect_3x3_stream_macros.svh"
module ed3_datapath #(
    parameter int MAX_WIDTH = ed3_pkg::DEF_MAX_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ed3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ed3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tuser,
    input  ed3_pkg::ed3_cmd_t              cmd,
    output ed3_pkg::ed3_status_t           status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast
);
    import ed3_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > 12) ? WW : 12;
    localparam int MW   = SQ_W + 1 + GAIN_W;

    // Configuration registers.
    logic [1:0]               mode_reg;
    logic [SQ_W-1:0]          thr_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    logic signed [GAIN_W-1:0] offset_reg;
    logic [CFG_DATA_W-1:0]    kx_reg, ky_reg;
    logic [11:0]              fw_reg;
    logic [ROW_W-1:0]         fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            thr_reg    <= '0;
            gain_reg   <= 16'sd256;
            offset_reg <= '0;
            kx_reg     <= '0;
            ky_reg     <= '0;
            fw_reg     <= 12'd640;
            fh_reg     <= 13'd480;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:      mode_reg   <= cfg_data[1:0];
                REG_THRESHOLD: thr_reg    <= cfg_data[SQ_W-1:0];
                REG_GAIN:      gain_reg   <= signed'(cfg_data[GAIN_W-1:0]);
                REG_OFFSET:    offset_reg <= signed'(cfg_data[GAIN_W-1:0]);
                REG_KERNEL_X:  kx_reg     <= cfg_data;
                REG_KERNEL_Y:  ky_reg     <= cfg_data;
                REG_WIDTH:     fw_reg     <= cfg_data[11:0];
                REG_HEIGHT:    fh_reg     <= cfg_data[ROW_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective geometry, saturated to the supported range.
    logic [WW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;
    always_comb begin
        if (CMPW'(fw_reg) < CMPW'(MIN_DIM))        eff_w = WW'(MIN_DIM);
        else if (CMPW'(fw_reg) > CMPW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
        else                                       eff_w = WW'(fw_reg);
        if (fh_reg < ROW_W'(MIN_DIM))              eff_h = ROW_W'(MIN_DIM);
        else if (fh_reg > ROW_W'(MAX_HEIGHT))      eff_h = ROW_W'(MAX_HEIGHT);
        else                                       eff_h = fh_reg;
    end

    // Input and output position counters.
    logic [AW-1:0]    in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [AW-1:0]    base_col;
    logic [ROW_W-1:0] base_row;
    logic             frame_done, emit_now, zero_now, last_now;

    always_comb begin
        frame_done = (in_row_reg == '0) && (in_col_reg == '0)
                   && ((out_row_reg != '0) || (out_col_reg != '0));
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        base_col     = frame_done ? '0 : out_col_reg;
        base_row     = frame_done ? '0 : out_row_reg;
        last_now     = 1'b0;
        zero_now     = 1'b1;
        if (s_tuser == OP_FLUSH) begin
            emit_now = frame_done;
            last_now = (out_row_reg == eff_h - 1'b1)
                     && ((AW + 1)'(out_col_reg) == (AW + 1)'(eff_w) - 1'b1);
            if (frame_done) begin
                if (last_now) begin
                    out_col_next = '0;
                    out_row_next = '0;
                end else if ((AW + 1)'(out_col_reg) + 1'b1 >= (AW + 1)'(eff_w)) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end else begin
            emit_now = !((in_row_reg == '0) || ((in_row_reg == 13'd1) && (in_col_reg == '0)));
            zero_now = (base_row == '0) || (base_row >= eff_h - 1'b1) || (base_col == '0)
                     || ((AW + 1)'(base_col) >= (AW + 1)'(eff_w) - 1'b1);
            if (emit_now) begin
                if ((AW + 1)'(base_col) + 1'b1 >= (AW + 1)'(eff_w)) begin
                    out_col_next = '0;
                    out_row_next = base_row + 1'b1;
                end else begin
                    out_col_next = base_col + 1'b1;
                    out_row_next = base_row;
                end
            end else begin
                out_col_next = base_col;
                out_row_next = base_row;
            end
            if ((AW + 1)'(in_col_reg) + 1'b1 >= (AW + 1)'(eff_w)) begin
                in_col_next = '0;
                in_row_next = ((ROW_W + 1)'(in_row_reg) + 1'b1 >= (ROW_W + 1)'(eff_h))
                            ? '0 : in_row_reg + 1'b1;
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT))) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cmd.accept) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Per-transaction flags and payload captured on acceptance.
    logic             flush_reg, emit_reg, zero_reg, last_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [AW-1:0]    col_reg;
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            flush_reg <= (s_tuser == OP_FLUSH);
            emit_reg  <= emit_now;
            zero_reg  <= zero_now;
            last_reg  <= last_now;
            pix_reg   <= s_tdata;
            col_reg   <= in_col_reg;
        end
    end

    // Line memories: read at acceptance, written back in the window cycle.
    logic [PIX_W-1:0] top_mem [MAX_WIDTH];
    logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_rd_reg, mid_rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) top_rd_reg <= top_mem[in_col_reg];
        if (cmd.win)    top_mem[col_reg] <= mid_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) mid_rd_reg <= mid_mem[in_col_reg];
        if (cmd.win)    mid_mem[col_reg] <= pix_reg;
    end

    // 3x3 window shift.
    logic [PIX_W-1:0] win_reg [TAPS];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) win_reg[i] <= '0;
        end else if (cmd.win) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[3 * r]     <= win_reg[3 * r + 1];
                win_reg[3 * r + 1] <= win_reg[3 * r + 2];
            end
            win_reg[2] <= top_rd_reg;
            win_reg[5] <= mid_rd_reg;
            win_reg[8] <= pix_reg;
        end
    end

    // Two-lane multiply-accumulate, one tap per cycle.
    logic [3:0]                    mac_k_reg;
    logic signed [ACC_W-1:0]       accx_reg, accy_reg;
    logic signed [COEF_W-1:0]      cx, cy;
    logic signed [PIX_W:0]         tap;
    logic signed [COEF_W+PIX_W:0]  px, py;
    always_comb begin
        cx  = signed'(kx_reg[COEF_W * mac_k_reg +: COEF_W]);
        cy  = signed'(ky_reg[COEF_W * mac_k_reg +: COEF_W]);
        tap = signed'({1'b0, win_reg[mac_k_reg]});
        px  = cx * tap;
        py  = cy * tap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_k_reg <= '0;
        end else if (cmd.mac_clear) begin
            mac_k_reg <= '0;
        end else if (cmd.mac_step && (mac_k_reg != MAC_LAST)) begin
            mac_k_reg <= mac_k_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_clear) begin
            accx_reg <= '0;
            accy_reg <= '0;
        end else if (cmd.mac_step) begin
            accx_reg <= accx_reg + ACC_W'(px);
            accy_reg <= accy_reg + ACC_W'(py);
        end
    end

    // Squares, gradient sum and gain product, each registered.
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, g_reg;
    logic signed [2*ACC_W-1:0] sqx_full, sqy_full;
    logic signed [SQ_W:0]     mul_a;
    logic signed [MW-1:0]     mul_reg;
    assign sqx_full = accx_reg * accx_reg;
    assign sqy_full = accy_reg * accy_reg;
    assign mul_a    = mode_reg[0] ? signed'({1'b0, g_reg}) : (SQ_W + 1)'(accx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.sq) begin
            sqx_reg <= SQ_W'(sqx_full);
            sqy_reg <= SQ_W'(sqy_full);
        end
        if (cmd.sum) g_reg   <= sqx_reg + sqy_reg;
        if (cmd.mul) mul_reg <= mul_a * gain_reg;
    end

    // Offset, shift and clamp, or threshold compare.
    logic signed [MW:0]     scaled_sum, scaled_sh, off_ext;
    logic [SQ_W-1:0]        mag, cmp_val;
    logic [PIX_W-1:0]       scaled_val, thr_val, result;
    always_comb begin
        off_ext    = (MW + 1)'(offset_reg);
        scaled_sum = (MW + 1)'(mul_reg) + (mode_reg[0] ? (off_ext <<< 8) : (off_ext <<< 4));
        scaled_sh  = mode_reg[0] ? (scaled_sum >>> 16) : (scaled_sum >>> 12);
        if (scaled_sum < 0)                        scaled_val = '0;
        else if (scaled_sh > (MW + 1)'(PIX_MAX))   scaled_val = PIX_MAX;
        else                                       scaled_val = scaled_sh[PIX_W-1:0];
        mag     = SQ_W'(accx_reg < 0 ? -accx_reg : accx_reg);
        cmp_val = mode_reg[0] ? g_reg : mag;
        thr_val = (cmp_val < thr_reg) ? '0 : PIX_MAX;
        result  = zero_reg ? '0 : (mode_reg[1] ? scaled_val : thr_val);
    end

    // Output register toward the result channel.
    logic             m_tvalid_reg, m_tlast_reg;
    logic [PIX_W-1:0] m_tdata_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_tdata_reg <= result;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign status.is_flush = flush_reg;
    assign status.emit     = emit_reg;
    assign status.zero     = zero_reg;
    assign status.mac_done = (mac_k_reg == MAC_LAST);
    assign status.out_free = !m_tvalid_reg || m_tready;

    `ED3_NEVER(a_mac_range, aclk, aresetn, (mac_k_reg > MAC_LAST), "tap counter out of range")
    `ED3_NEVER(a_in_col_range, aclk, aresetn, ((AW + 1)'(in_col_reg) >= (AW + 1)'(eff_w)), "input column beyond width")
    `ED3_NEVER(a_out_row_range, aclk, aresetn, (out_row_reg >= eff_h), "output row beyond height")
    `ED3_ASSERT(a_tail_zero, aclk, aresetn, (m_tvalid && m_tlast) |-> (m_tdata == '0), "frame tail not zero")

endmodule
